// File: hdl/tpb_pkg.sv
// Shared types and constants for the thread placement balancer.
// Holds field widths, request and path codes, register indexes and the sequencer states.
// No dependencies.
package tpb_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int MODE_W   = 2;
    localparam int CPU_W    = 4;
    localparam int PATH_W   = 2;
    localparam int TCOUNT_W = 16;
    localparam int GLOBAL_W = 20;
    localparam int BIAS_W   = 10;
    localparam int ONLINE_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = BIAS_W;

    // Widths of the packed stream words
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // Width able to hold a processor total of up to 127
    localparam int LIM_W = 7;

    // Percentage scale and its width
    localparam int PCT_SCALE = 100;
    localparam int PCT_W     = 7;

    // Defaults of the top-level parameters and of the registers
    localparam int DEF_MAX_CPUS   = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam logic [BIAS_W-1:0]   BIAS_RESET   = BIAS_W'(100);
    localparam logic [ONLINE_W-1:0] ONLINE_RESET = ONLINE_W'(16);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ONLINE = 1'b1;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PLACE   = 2'd0,
        MODE_SUSPEND = 2'd1,
        MODE_YIELD   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // Result path codes
    typedef enum logic [PATH_W-1:0] {
        PATH_LOCAL = 2'd0,
        PATH_IDLE  = 2'd1,
        PATH_LEAST = 2'd2,
        PATH_POP   = 2'd3
    } path_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_FETCH,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_UPDATE
    } state_t;

endpackage

// File: hdl/tpb_count_mem.sv
// Ready-count store of the thread placement balancer: one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on nothing but its parameters.
module tpb_count_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_ok_reg;

    // Storage array and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid bits cleared at once by reset; the read side samples the bit with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= valid_reg[rd_addr];
        end
    end

    // An entry never written reads as zero
    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

// File: hdl/thread_placement_balancer.sv
// Thread placement balancer: per-processor ready counts, global count and idle mask.
// A pop or unused request passes the load and update states; a local placement adds the
// local check, an idle placement the check and a fetch, and a least-loaded one the check
// and a scan of N counts, N being the online processor count (one count compared per cycle
// in the shared compare unit). One request at a time: the next beat is taken once the
// result is registered, later under back-pressure. Reset (rst_n, asynchronous, active low)
// zeroes all counts and the idle mask and restores the registers.
module thread_placement_balancer #(
    parameter int MAX_CPUS   = tpb_pkg::DEF_MAX_CPUS,
    parameter int COUNT_BITS = tpb_pkg::DEF_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tpb_pkg::S_DATA_W-1:0]  s_tdata,  // mode[1:0], cpu[5:2], zero[7:6]
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tpb_pkg::M_DATA_W-1:0]  m_tdata,  // target_cpu[3:0], placement_path[5:4],
                                                    // took_thread[6], target_count[22:7],
                                                    // zero[23]
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [tpb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpb_pkg::CFG_W-1:0]     cfg_data
);

    import tpb_pkg::*;

    localparam int IDX_W  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int LHS_W  = COUNT_BITS + 1 + PCT_W;
    localparam int PROD_W = GLOBAL_W + 1 + BIAS_W;
    localparam int CMP_W  = (LHS_W > PROD_W) ? LHS_W : PROD_W;

    // Sequencer and request registers
    state_t                  state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic [IDX_W-1:0]        cpu_reg, cpu_next;
    logic [COUNT_BITS-1:0]   own_reg, own_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [IDX_W-1:0]        target_reg, target_next;
    logic [COUNT_BITS-1:0]   tcount_reg, tcount_next;
    path_t                   path_reg, path_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [LIM_W-1:0]        scan_end_reg, scan_end_next;

    // Architectural state and configuration
    logic [GLOBAL_W-1:0]     global_reg, global_next;
    logic [MAX_CPUS-1:0]     idle_mask_reg, idle_mask_next;
    logic [BIAS_W-1:0]       bias_reg;
    logic [ONLINE_W-1:0]     online_reg;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [CPU_W-1:0]        out_target_reg, out_target_next;
    path_t                   out_path_reg, out_path_next;
    logic                    out_took_reg, out_took_next;
    logic [TCOUNT_W-1:0]     out_count_reg, out_count_next;

    // Count store port signals
    logic [IDX_W-1:0]        rd_addr;
    logic [COUNT_BITS-1:0]   rd_data;
    logic                    wr_en;
    logic [COUNT_BITS-1:0]   wr_data;

    // Decoded and derived values
    logic [CPU_W-1:0]        s_cpu;
    logic [IDX_W-1:0]        cpu_idx;
    logic                    idle_hit;
    logic [IDX_W-1:0]        idle_idx;
    logic [LIM_W-1:0]        online_ext;
    logic [LIM_W-1:0]        n_eff;
    logic [CMP_W-1:0]        local_lhs;
    logic                    local_ok;
    logic                    scan_take;
    logic                    scan_last;
    logic                    out_free;
    logic [MAX_CPUS-1:0]     cpu_bit;
    logic [COUNT_BITS-1:0]   count_inc;
    logic [COUNT_BITS-1:0]   count_dec;

    tpb_count_mem #(
        .DEPTH (MAX_CPUS),
        .WIDTH (COUNT_BITS),
        .AW    (IDX_W)
    ) u_count_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (target_reg),
        .wr_data (wr_data)
    );

    // Requester index folded onto the processor range
    assign s_cpu = s_tdata[MODE_W +: CPU_W];

    always_comb
    begin
        cpu_idx = '0;
        for (int i = 0; i < (1 << CPU_W); i++)
        begin
            if (s_cpu == CPU_W'(i))
            begin
                cpu_idx = IDX_W'(i % MAX_CPUS);
            end
        end
    end

    // Lowest processor with its idle bit set
    always_comb
    begin
        idle_hit = 1'b0;
        idle_idx = '0;
        for (int i = MAX_CPUS - 1; i >= 0; i--)
        begin
            if (idle_mask_reg[i])
            begin
                idle_hit = 1'b1;
                idle_idx = IDX_W'(i);
            end
        end
    end

    // Number of processors searched, limited to the processors present
    assign online_ext = LIM_W'(online_reg);
    assign n_eff      = (online_ext > LIM_W'(MAX_CPUS)) ? LIM_W'(MAX_CPUS) : online_ext;

    // Local test: count+1 < floor(P/100) is the same as 100*(count+2) <= P
    assign local_lhs = CMP_W'((COUNT_BITS + 1)'(own_reg) + (COUNT_BITS + 1)'(2))
                       * CMP_W'(PCT_SCALE);
    assign local_ok  = local_lhs <= CMP_W'(prod_reg);

    // Shared compare unit of the least-loaded search
    assign scan_take = cmp_vld_reg && (rd_data < tcount_reg);
    assign scan_last = (LIM_W'(scan_idx_reg) == (scan_end_reg - LIM_W'(1)));

    // Saturating count updates and the requester's idle bit
    assign count_inc = (tcount_reg == '1) ? tcount_reg : tcount_reg + 1'b1;
    assign count_dec = tcount_reg - 1'b1;
    assign cpu_bit   = MAX_CPUS'(1) << cpu_reg;

    assign out_free = !out_valid_reg || m_tready;

    // Sequencer: next state, datapath next values and store control
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cpu_next        = cpu_reg;
        own_next        = own_reg;
        prod_next       = prod_reg;
        target_next     = target_reg;
        tcount_next     = tcount_reg;
        path_next       = path_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        scan_end_next   = scan_end_reg;
        global_next     = global_reg;
        idle_mask_next  = idle_mask_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_target_next = out_target_reg;
        out_path_next   = out_path_reg;
        out_took_next   = out_took_reg;
        out_count_next  = out_count_reg;
        rd_addr         = cpu_reg;
        wr_en           = 1'b0;
        wr_data         = count_inc;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_addr  = cpu_idx;
                if (s_tvalid)
                begin
                    mode_next  = mode_t'(s_tdata[MODE_W-1:0]);
                    cpu_next   = cpu_idx;
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                own_next    = rd_data;
                tcount_next = rd_data;
                target_next = cpu_reg;
                prod_next   = PROD_W'((GLOBAL_W + 1)'(global_reg) + (GLOBAL_W + 1)'(1))
                              * PROD_W'(bias_reg);
                if (mode_reg == MODE_PLACE)
                begin
                    path_next  = PATH_LOCAL;
                    state_next = ST_CHECK;
                end
                else
                begin
                    path_next  = PATH_POP;
                    state_next = ST_UPDATE;
                end
            end

            ST_CHECK:
            begin
                if (local_ok)
                begin
                    path_next  = PATH_LOCAL;
                    state_next = ST_UPDATE;
                end
                else if (idle_hit)
                begin
                    path_next   = PATH_IDLE;
                    target_next = idle_idx;
                    rd_addr     = idle_idx;
                    state_next  = ST_FETCH;
                end
                else
                begin
                    path_next     = PATH_LEAST;
                    scan_end_next = n_eff;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    state_next    = (n_eff == '0) ? ST_UPDATE : ST_SCAN;
                end
            end

            ST_FETCH:
            begin
                tcount_next = rd_data;
                state_next  = ST_UPDATE;
            end

            ST_SCAN:
            begin
                rd_addr      = scan_idx_reg;
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (scan_take)
                begin
                    tcount_next = rd_data;
                    target_next = cmp_idx_reg;
                end
                if (scan_last)
                begin
                    state_next = ST_SCAN_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_SCAN_LAST:
            begin
                if (scan_take)
                begin
                    tcount_next = rd_data;
                    target_next = cmp_idx_reg;
                end
                state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_target_next = CPU_W'(target_reg);
                    out_path_next   = path_reg;
                    out_took_next   = 1'b0;
                    out_count_next  = TCOUNT_W'(tcount_reg);
                    state_next      = ST_IDLE;

                    case (mode_reg) inside
                        MODE_PLACE:
                        begin
                            wr_en          = 1'b1;
                            wr_data        = count_inc;
                            out_count_next = TCOUNT_W'(count_inc);
                            if (global_reg != '1)
                            begin
                                global_next = global_reg + 1'b1;
                            end
                        end
                        MODE_SUSPEND, MODE_YIELD:
                        begin
                            if (tcount_reg == '0)
                            begin
                                idle_mask_next = idle_mask_reg | cpu_bit;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_data        = count_dec;
                                out_took_next  = 1'b1;
                                out_count_next = TCOUNT_W'(count_dec);
                                if (global_reg != '0)
                                begin
                                    global_next = global_reg - 1'b1;
                                end
                                if (mode_reg == MODE_YIELD)
                                begin
                                    idle_mask_next = idle_mask_reg & ~cpu_bit;
                                end
                            end
                        end
                        default:
                        begin
                            // Unused request code: report the count and change nothing
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control state, architectural state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            global_reg    <= '0;
            idle_mask_reg <= '0;
            bias_reg      <= BIAS_RESET;
            online_reg    <= ONLINE_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            global_reg    <= global_next;
            idle_mask_reg <= idle_mask_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BIAS:   bias_reg   <= cfg_data[BIAS_W-1:0];
                    REG_ONLINE: online_reg <= cfg_data[ONLINE_W-1:0];
                    default:    bias_reg   <= bias_reg;
                endcase
            end
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        cpu_reg        <= cpu_next;
        own_reg        <= own_next;
        prod_reg       <= prod_next;
        target_reg     <= target_next;
        tcount_reg     <= tcount_next;
        path_reg       <= path_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_vld_reg    <= cmp_vld_next;
        scan_end_reg   <= scan_end_next;
        out_target_reg <= out_target_next;
        out_path_reg   <= out_path_next;
        out_took_reg   <= out_took_next;
        out_count_reg  <= out_count_next;
    end

    // Output beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_took_reg, out_path_reg, out_target_reg};

endmodule
